### rtl/core/avdd_pkg.sv
// Shared types and constants for the audio/video desync drop decider.
`default_nettype none

package avdd_pkg;

    localparam int TIME_W     = 48;   // audio/video timestamp width
    localparam int DIFF_W     = 49;   // signed video minus audio
    localparam int THR_W      = 24;   // late_threshold width
    localparam int LIM_W      = 6;    // drop_limit width
    localparam int CNT_W      = 6;    // drop counter width
    localparam int OFS_W      = 55;   // accepted offset width (signed)
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int DIG_W      = 4;    // quotient bits retired per divider stage
    localparam int RADIX      = 16;

    localparam logic [THR_W-1:0] THR_RST = THR_W'(800000);
    localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(50);

    localparam logic [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LATE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LIMIT     = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_NO_VIDEO = 3'd0,
        ST_FILLING  = 3'd1,
        ST_IN_BAND  = 3'd2,
        ST_RESYNC   = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_ACCEPTED = 3'd5
    } t_status;

    // what the ring stage did with a transaction
    typedef enum logic [1:0] {
        KIND_NO_VIDEO = 2'd0,
        KIND_FILL     = 2'd1,
        KIND_FULL     = 2'd2
    } t_kind;

    // sideband that travels alongside the divider pipeline
    typedef struct packed {
        t_kind kind;
        logic  restart;
        logic  neg;
    } t_side;

endpackage

`default_nettype wire

### rtl/core/avdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module avdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/av_desync_audio_drop_decider_unit.sv
// Top level of the audio/video desync drop decider.
// Path from input to result transaction: input register, ring stage, magnitude stage, the
//   radix-16 divide-by-WINDOW digit stages, sign stage and result register.
// Throughput: one transaction per cycle; every stage advances whenever the result
//   register is empty or being drained.
// Reset (sync, active low): empties the pipeline, clears fill count, ring head, sum, drop
//   counter and accepted offset, loads register defaults; ring contents are not cleared.
`default_nettype none

module av_desync_audio_drop_decider_unit #(
    parameter int WINDOW = 100
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [avdd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [avdd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [avdd_pkg::TIME_W-1:0]           i_audio_time,
    input  wire logic [avdd_pkg::TIME_W-1:0]           i_video_time,
    input  wire logic                                  i_video_valid,
    input  wire logic                                  i_restart,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_present,
    output logic      [avdd_pkg::STAT_W-1:0]           o_status,
    output logic signed [avdd_pkg::DIFF_W-1:0]         o_average_desync
);

    localparam int DIFF_W = avdd_pkg::DIFF_W;
    localparam int OFS_W  = avdd_pkg::OFS_W;
    localparam int THR_W  = avdd_pkg::THR_W;
    localparam int CNT_W  = avdd_pkg::CNT_W;
    localparam int DIG_W  = avdd_pkg::DIG_W;
    localparam int AW     = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    // |sum| <= WINDOW * (2^48 - 1), so the magnitude needs 48 + clog2(WINDOW) bits
    localparam int SUM_W  = DIFF_W + $clog2(WINDOW);
    localparam int ABS_W  = SUM_W - 1;
    localparam int NDIG   = (ABS_W + DIG_W - 1) / DIG_W;
    localparam int DIV_W  = NDIG * DIG_W;
    localparam int REM_W  = $clog2(WINDOW);
    localparam int VAL_W  = REM_W + DIG_W;
    localparam int CMP_W  = OFS_W + 2;   // room for threshold + offset and the compare

    localparam logic [AW-1:0]     HEAD_LAST = AW'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the result register is free
    // or its transaction is being taken.
    // ------------------------------------------------------------------
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]           r_thr;
    logic [avdd_pkg::LIM_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= avdd_pkg::THR_RST;
            r_limit <= avdd_pkg::LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                avdd_pkg::REG_LATE_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                avdd_pkg::REG_DROP_LIMIT:     r_limit <= i_cfg_data[avdd_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register. The video minus audio difference is formed
    // on the way in, so the ring stage sees it ready.
    // ------------------------------------------------------------------
    logic                     r0_vld;
    logic signed [DIFF_W-1:0] r0_diff;
    logic                     r0_vvalid;
    logic                     r0_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_diff    <= $signed({1'b0, i_video_time}) - $signed({1'b0, i_audio_time});
            r0_vvalid  <= i_video_valid;
            r0_restart <= i_restart;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: ring and running sum. The RAM read port always points at the
    // head the next transaction will see, so the oldest entry is waiting in
    // the read register when that transaction arrives.
    // ------------------------------------------------------------------
    typedef avdd_pkg::t_kind t_kind_local;

    logic [FILL_W-1:0]       r_fill;
    logic [AW-1:0]           r_head;
    logic signed [SUM_W-1:0] r_sum;

    logic [FILL_W-1:0]       n_fill;
    logic [AW-1:0]           n_head;
    logic signed [SUM_W-1:0] n_sum;

    logic                     w_ring_full;
    logic                     w_fire1;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic signed [DIFF_W-1:0] w_old;
    logic signed [DIFF_W:0]   w_delta;
    t_kind_local              w_kind;

    assign w_ring_full = (r_fill == FILL_FULL);
    assign w_fire1     = r0_vld && w_en;
    assign w_we        = w_fire1 && r0_vvalid;
    assign w_waddr     = w_ring_full ? r_head : r_fill[AW-1:0];

    avdd_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r0_diff),
        .i_raddr (n_head),
        .o_rdata (w_old)
    );

    always_comb begin
        n_fill  = r_fill;
        n_head  = r_head;
        n_sum   = r_sum;
        w_kind  = avdd_pkg::KIND_NO_VIDEO;
        w_delta = (DIFF_W + 1)'(r0_diff);
        if (r0_vvalid) begin
            if (w_ring_full) begin
                w_kind  = avdd_pkg::KIND_FULL;
                // newest replaces oldest
                w_delta = (DIFF_W + 1)'(r0_diff) - (DIFF_W + 1)'(w_old);
                if (w_fire1) begin
                    n_head = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
                end
            end else begin
                w_kind = avdd_pkg::KIND_FILL;
                if (w_fire1) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            if (w_fire1) begin
                n_sum = r_sum + SUM_W'(w_delta);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_head <= '0;
            r_sum  <= '0;
        end else begin
            r_fill <= n_fill;
            r_head <= n_head;
            r_sum  <= n_sum;
        end
    end

    logic                    r1_vld;
    avdd_pkg::t_side         r1_side;
    logic signed [SUM_W-1:0] r1_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side.kind    <= w_kind;
            r1_side.restart <= r0_restart;
            r1_side.neg     <= 1'b0;
            r1_sum          <= n_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude and sign of the window sum (division truncates
    // toward zero, so divide the magnitude and reapply the sign).
    // ------------------------------------------------------------------
    logic                    w_neg;
    logic signed [SUM_W-1:0] w_mag_s;

    assign w_neg   = r1_sum[SUM_W-1];
    assign w_mag_s = w_neg ? -r1_sum : r1_sum;

    // divider pipeline: index 0 is the magnitude stage, index k+1 follows digit stage k
    logic                  r_dv_vld  [NDIG+1];
    avdd_pkg::t_side       r_dv_side [NDIG+1];
    logic [DIV_W-1:0]      r_dv_dvd  [NDIG+1];
    logic [DIV_W-1:0]      r_dv_quo  [NDIG+1];
    logic [REM_W-1:0]      r_dv_rem  [NDIG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0].kind    <= r1_side.kind;
            r_dv_side[0].restart <= r1_side.restart;
            r_dv_side[0].neg     <= w_neg;
            r_dv_dvd[0]          <= DIV_W'(w_mag_s[ABS_W-1:0]);
            r_dv_quo[0]          <= '0;
            r_dv_rem[0]          <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Digit stages: radix-16 long division by WINDOW, most significant
    // digit first. Each stage compares rem:digit against the fifteen
    // constant multiples of WINDOW.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NDIG; k++) begin : g_dig
        localparam int J = NDIG - 1 - k;

        logic [VAL_W-1:0] w_val;
        logic [DIG_W-1:0] w_digit;
        logic [VAL_W-1:0] w_sub;
        logic [DIV_W-1:0] w_quo;

        always_comb begin
            w_val   = {r_dv_rem[k], r_dv_dvd[k][DIG_W*J +: DIG_W]};
            w_digit = '0;
            for (int c = 1; c < avdd_pkg::RADIX; c++) begin
                if (w_val >= VAL_W'(c * WINDOW)) begin
                    w_digit = w_digit + DIG_W'(1);
                end
            end
            w_sub = VAL_W'(w_digit) * VAL_W'(WINDOW);
            w_quo = r_dv_quo[k];
            w_quo[DIG_W*J +: DIG_W] = w_digit;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_side[k+1] <= r_dv_side[k];
                r_dv_dvd[k+1]  <= r_dv_dvd[k];
                r_dv_quo[k+1]  <= w_quo;
                r_dv_rem[k+1]  <= w_val[REM_W-1:0] - w_sub[REM_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sign stage: signed, truncated average. Quotient < 2^48 fits the field.
    // ------------------------------------------------------------------
    logic                     r_sg_vld;
    avdd_pkg::t_side          r_sg_side;
    logic signed [DIFF_W-1:0] r_sg_avg;
    logic signed [DIFF_W-1:0] w_quo_s;

    assign w_quo_s = $signed(r_dv_quo[NDIG][DIFF_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg_vld <= 1'b0;
        end else if (w_en) begin
            r_sg_vld <= r_dv_vld[NDIG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sg_side <= r_dv_side[NDIG];
            r_sg_avg  <= r_dv_side[NDIG].neg ? -w_quo_s : w_quo_s;
        end
    end

    // ------------------------------------------------------------------
    // Decision stage: restart, band compare, drop counter and accepted
    // offset. Writes the result register.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]        r_cnt;
    logic signed [OFS_W-1:0] r_ofs;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [OFS_W-1:0] n_ofs;

    logic [CNT_W-1:0]        w_cur_cnt;
    logic signed [OFS_W-1:0] w_cur_ofs;
    logic signed [CMP_W-1:0] w_avg_x;
    logic signed [CMP_W-1:0] w_thr_x;
    logic signed [CMP_W-1:0] w_bound;
    logic                    w_above;
    logic                    w_below;
    logic [CNT_W:0]          w_cnt_inc;
    logic signed [OFS_W:0]   w_ofs_sum;
    logic signed [OFS_W-1:0] w_ofs_sat;

    logic                     n_present;
    avdd_pkg::t_status        n_status;
    logic signed [DIFF_W-1:0] n_avg;

    assign w_cur_cnt = r_sg_side.restart ? '0 : r_cnt;
    assign w_cur_ofs = r_sg_side.restart ? '0 : r_ofs;
    assign w_avg_x   = CMP_W'(r_sg_avg);
    assign w_thr_x   = $signed(CMP_W'(r_thr));
    assign w_bound   = w_thr_x + CMP_W'(w_cur_ofs);
    assign w_above   = w_avg_x > w_bound;
    assign w_below   = w_avg_x < w_thr_x;
    assign w_cnt_inc = {1'b0, w_cur_cnt} + (CNT_W + 1)'(1);
    assign w_ofs_sum = (OFS_W + 1)'(w_cur_ofs) + (OFS_W + 1)'(r_sg_avg);

    // saturate to the offset's signed range
    always_comb begin
        if (w_ofs_sum[OFS_W] != w_ofs_sum[OFS_W-1]) begin
            w_ofs_sat = w_ofs_sum[OFS_W] ? $signed(avdd_pkg::OFS_MIN)
                                         : $signed(avdd_pkg::OFS_MAX);
        end else begin
            w_ofs_sat = w_ofs_sum[OFS_W-1:0];
        end
    end

    always_comb begin
        n_cnt     = w_cur_cnt;
        n_ofs     = w_cur_ofs;
        n_present = 1'b1;
        n_avg     = '0;
        n_status  = avdd_pkg::ST_NO_VIDEO;
        case (r_sg_side.kind)
            avdd_pkg::KIND_FILL: begin
                n_status = avdd_pkg::ST_FILLING;
            end
            avdd_pkg::KIND_FULL: begin
                n_avg = r_sg_avg;
                if (w_above) begin
                    if (w_cnt_inc < {1'b0, r_limit}) begin
                        n_cnt     = w_cnt_inc[CNT_W-1:0];
                        n_present = 1'b0;
                        n_status  = avdd_pkg::ST_DROPPED;
                    end else begin
                        // give up dropping: take the lag as the new baseline
                        n_ofs    = w_ofs_sat;
                        n_cnt    = '0;
                        n_status = avdd_pkg::ST_ACCEPTED;
                    end
                end else if (w_below) begin
                    n_cnt    = '0;
                    n_ofs    = '0;
                    n_status = avdd_pkg::ST_RESYNC;
                end else begin
                    n_status = avdd_pkg::ST_IN_BAND;
                end
            end
            default: ;
        endcase
    end

    logic w_fire_out;
    assign w_fire_out = r_sg_vld && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ofs <= '0;
        end else if (w_fire_out) begin
            r_cnt <= n_cnt;
            r_ofs <= n_ofs;
        end
    end

    // result register
    logic                     r_out_vld;
    logic                     r_present;
    avdd_pkg::t_status        r_status;
    logic signed [DIFF_W-1:0] r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_sg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_present <= n_present;
            r_status  <= n_status;
            r_avg     <= n_avg;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_present        = r_present;
    assign o_status         = r_status;
    assign o_average_desync = r_avg;

endmodule

`default_nettype wire
